### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int REG_BYTES       = 8;
    localparam int CFG_W           = REG_BYTES * BYTE_W;
    localparam int LEN_W           = 4;
    localparam int IDX_W           = 8;
    localparam int OUT_DEPTH       = 8;
    localparam int OCNT_W          = 4;
    localparam int RCOUNT_W        = 16;

    localparam int MAX_FIND_DEF    = 8;
    localparam int MAX_REPLACE_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;

    typedef enum logic [IDX_W-1:0] {
        REG_FIND_BYTES    = 8'd0,
        REG_FIND_LENGTH   = 8'd1,
        REG_REPLACE_BYTES = 8'd2,
        REG_REPLACE_LENGTH = 8'd3
    } t_reg_idx;

    typedef struct packed {
        logic en;
        logic ins;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic [OUT_DEPTH-1:0][BYTE_W-1:0] bytes;
        logic [OCNT_W-1:0]                cnt;
        logic                             byte_valid;
        logic                             last;
        logic [RCOUNT_W-1:0]              rcount;
    } t_load;

endpackage

### hw/rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// One window byte: takes the incoming byte, compares with its pattern byte,
// and shifts toward the oldest end on a mismatch.
// ----------------------------------------------------------------------------
module sfr_cell (
    input  logic                      i_clk,
    input  sfr_pkg::t_cell_ctl        i_ctl,
    input  logic [sfr_pkg::BYTE_W-1:0] i_in_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_find_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_next_byte,
    output logic [sfr_pkg::BYTE_W-1:0] o_cur_byte,
    output logic                      o_eq
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    always_comb begin
        o_cur_byte = i_ctl.ins ? i_in_byte : r_byte;
        o_eq       = (o_cur_byte == i_find_byte);
        n_byte     = i_ctl.shift ? i_next_byte : o_cur_byte;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_byte <= n_byte;
        end
    end

endmodule

### hw/rtl/sfr_out_buf.sv
// ----------------------------------------------------------------------------
// sfr_out_buf
// Result buffer: holds the results of one item and hands them out one per
// cycle while the receiver is ready, oldest first.
// ----------------------------------------------------------------------------
module sfr_out_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load_en,
    input  sfr_pkg::t_load               i_load,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [sfr_pkg::BYTE_W-1:0]   o_byte,
    output logic                         o_byte_valid,
    output logic                         o_last,
    output logic [sfr_pkg::RCOUNT_W-1:0] o_rcount,
    output logic                         o_free
);
    import sfr_pkg::*;

    logic [OUT_DEPTH-1:0][BYTE_W-1:0] r_bytes;
    logic [OCNT_W-1:0]                r_cnt;
    logic                             r_bvalid;
    logic                             r_last;
    logic [RCOUNT_W-1:0]              r_rcount;
    logic                             take;

    assign o_valid      = (r_cnt != '0);
    assign take         = o_valid && i_ready;
    assign o_free       = (r_cnt == '0) || ((r_cnt == OCNT_W'(1)) && i_ready);
    assign o_byte       = r_bytes[0];
    assign o_byte_valid = r_bvalid;
    assign o_last       = r_last && (r_cnt == OCNT_W'(1));
    assign o_rcount     = r_rcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load_en) begin
            r_cnt <= i_load.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_bytes  <= i_load.bytes;
            r_bvalid <= i_load.byte_valid;
            r_last   <= i_load.last;
            r_rcount <= i_load.rcount;
        end else if (take) begin
            for (int k = 0; k < OUT_DEPTH - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
            r_bytes[OUT_DEPTH-1] <= '0;
        end
    end

endmodule

### hw/rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming find-and-replace over a byte stream with a row of window cells.
// ----------------------------------------------------------------------------
// Rewrites a byte stream, replacing every leftmost non-overlapping match of
// the find pattern by the replacement; the registers are latched on the first
// item of a stream. An item with at most one result is taken every cycle
// while the receiver is ready; one with several (a replacement, or the flush
// at end of stream) holds the input until the result buffer, which hands out
// one result per ready cycle, has all but the last out. The comparison is a
// row of window cells, one per pattern byte, each holding one pending byte.
module stream_find_and_replace #(
    parameter int MAX_FIND    = sfr_pkg::MAX_FIND_DEF,
    parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF,
    parameter int COUNT_BITS  = sfr_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sfr_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                         i_end_of_stream,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_byte_valid,
    output logic                         o_last,
    output logic [sfr_pkg::RCOUNT_W-1:0] o_replace_count
);
    import sfr_pkg::*;

    localparam int CELLS = (MAX_FIND < REG_BYTES) ? MAX_FIND : REG_BYTES;
    localparam int RMAX  = (MAX_REPLACE < REG_BYTES) ? MAX_REPLACE : REG_BYTES;
    localparam int FW    = $clog2(CELLS + 1);

    // configuration registers
    logic [CFG_W-1:0] r_cfg_find;
    logic [LEN_W-1:0] r_cfg_flen;
    logic [CFG_W-1:0] r_cfg_repl;
    logic [LEN_W-1:0] r_cfg_rlen;

    // per-stream copies
    logic             r_in_stream;
    logic [CFG_W-1:0] r_act_find;
    logic [CFG_W-1:0] r_act_repl;
    logic [FW-1:0]    r_act_flen;
    logic [LEN_W-1:0] r_act_rlen;

    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         n_fill;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] count_upd;

    logic [FW-1:0]    flen_c;
    logic [LEN_W-1:0] rlen_c;
    logic [CFG_W-1:0] find_use;
    logic [CFG_W-1:0] repl_use;
    logic [FW-1:0]    flen;
    logic [LEN_W-1:0] rlen;

    logic                         accept;
    logic [CELLS-1:0][BYTE_W-1:0] pw;
    logic [CELLS-1:0]             eq;
    logic [CELLS-1:0]             mask;
    t_cell_ctl [CELLS-1:0]        ctl;
    logic [FW-1:0]                pfill;
    logic                         full;
    logic                         hit;
    logic                         miss;
    logic                         sel_repl;
    logic [OCNT_W-1:0]            n_res;
    logic                         bare;
    logic [31:0]                  count_ext;
    t_load                        load;
    logic                         buf_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = buf_free;
    assign accept      = i_in_valid && buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_find <= '0;
            r_cfg_flen <= '0;
            r_cfg_repl <= '0;
            r_cfg_rlen <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FIND_BYTES:     r_cfg_find <= i_cfg_data;
                REG_FIND_LENGTH:    r_cfg_flen <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES:  r_cfg_repl <= i_cfg_data;
                REG_REPLACE_LENGTH: r_cfg_rlen <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(r_cfg_flen) > CELLS) begin
            flen_c = FW'(CELLS);
        end else begin
            flen_c = FW'(r_cfg_flen);
        end
        if (32'(r_cfg_rlen) > RMAX) begin
            rlen_c = LEN_W'(RMAX);
        end else begin
            rlen_c = r_cfg_rlen;
        end
        find_use = r_in_stream ? r_act_find : r_cfg_find;
        repl_use = r_in_stream ? r_act_repl : r_cfg_repl;
        flen     = r_in_stream ? r_act_flen : flen_c;
        rlen     = r_in_stream ? r_act_rlen : rlen_c;
    end

    // window cells
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic [BYTE_W-1:0] next_byte;
        if (g < CELLS - 1) begin : g_mid
            assign next_byte = pw[g+1];
        end else begin : g_end
            assign next_byte = '0;
        end

        assign ctl[g].en    = accept && (flen != '0);
        assign ctl[g].ins   = (r_fill == FW'(g));
        assign ctl[g].shift = miss;
        assign mask[g]      = (FW'(g) < flen);

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl[g]),
            .i_in_byte   (i_in_byte),
            .i_find_byte (find_use[g*BYTE_W +: BYTE_W]),
            .i_next_byte (next_byte),
            .o_cur_byte  (pw[g]),
            .o_eq        (eq[g])
        );
    end

    always_comb begin
        pfill     = r_fill + 1'b1;
        full      = (flen != '0) && (pfill == flen);
        hit       = full && (&(eq | ~mask));
        miss      = full && !hit;
        count_upd = (hit && (r_count != '1)) ? r_count + 1'b1 : r_count;
        sel_repl  = hit;

        if (flen == '0) begin
            n_res = OCNT_W'(1);
        end else if (hit) begin
            n_res = OCNT_W'(rlen);
        end else if (full) begin
            n_res = i_end_of_stream ? OCNT_W'(flen) : OCNT_W'(1);
        end else begin
            n_res = i_end_of_stream ? OCNT_W'(pfill) : '0;
        end
        bare = i_end_of_stream && (n_res == '0);

        for (int k = 0; k < OUT_DEPTH; k++) begin
            load.bytes[k] = '0;
            if (sel_repl) begin
                if (k < RMAX) begin
                    load.bytes[k] = repl_use[k*BYTE_W +: BYTE_W];
                end
            end else if (k < CELLS) begin
                load.bytes[k] = pw[k];
            end
        end
        if (bare) begin
            load.bytes[0] = '0;
        end

        count_ext       = 32'(count_upd);
        load.cnt        = bare ? OCNT_W'(1) : n_res;
        load.byte_valid = !bare;
        load.last       = i_end_of_stream;
        load.rcount     = count_ext[RCOUNT_W-1:0];

        if (i_end_of_stream || (flen == '0) || hit) begin
            n_fill = '0;
        end else if (miss) begin
            n_fill = flen - 1'b1;
        end else begin
            n_fill = pfill;
        end
        n_count = i_end_of_stream ? '0 : count_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stream <= 1'b0;
            r_fill      <= '0;
            r_count     <= '0;
            r_act_find  <= '0;
            r_act_repl  <= '0;
            r_act_flen  <= '0;
            r_act_rlen  <= '0;
        end else if (accept) begin
            r_in_stream <= !i_end_of_stream;
            r_fill      <= n_fill;
            r_count     <= n_count;
            if (!r_in_stream) begin
                r_act_find <= r_cfg_find;
                r_act_repl <= r_cfg_repl;
                r_act_flen <= flen_c;
                r_act_rlen <= rlen_c;
            end
        end
    end

    sfr_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_en    (accept),
        .i_load       (load),
        .i_ready      (i_out_ready),
        .o_valid      (o_out_valid),
        .o_byte       (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_rcount     (o_replace_count),
        .o_free       (buf_free)
    );

endmodule

### test/tb_stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace
// Self-checking testbench for the stream find-and-replace block.
// ----------------------------------------------------------------------------
// Each accepted byte runs through an in-bench rewriter that keeps its own
// window, counter and latched pattern. The rewriter queues the bytes it
// expects to see, and every output item is checked against the head of that
// queue. Directed streams cover pass-through, replace and flush, deletion down
// to a bare end marker, oversized lengths, latching of the registers at
// stream start and the running replace count over a run of matches. Random
// streams follow, built mostly from pattern copies (whole or cut short) over a
// small alphabet. Sender gaps and receiver stalls vary from one stream to the
// next.
// ----------------------------------------------------------------------------
module tb_stream_find_and_replace;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 16;
    localparam int MAX_ERR_LOG = 50;

    typedef struct packed {
        logic [BYTE_W-1:0]   text;
        logic                vld;
        logic                fin;
        logic [RCOUNT_W-1:0] cnt;
    } t_text_out;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index     = '0;
    logic [CFG_W-1:0]    i_cfg_data      = '0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_ready;
    logic [BYTE_W-1:0]   i_in_byte       = '0;
    logic                i_end_of_stream = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready     = 1'b0;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_byte_valid;
    logic                o_last;
    logic [RCOUNT_W-1:0] o_replace_count;

    stream_find_and_replace dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_replace_count (o_replace_count)
    );

    // register shadows and the copies latched at stream start
    logic [CFG_W-1:0] cfg_find  = '0;
    logic [CFG_W-1:0] cfg_repl  = '0;
    logic [LEN_W-1:0] cfg_flen  = '0;
    logic [LEN_W-1:0] cfg_rlen  = '0;
    logic [CFG_W-1:0] act_find  = '0;
    logic [CFG_W-1:0] act_repl  = '0;
    int unsigned      act_flen  = 0;
    int unsigned      act_rlen  = 0;
    bit               in_stream = 1'b0;

    logic [BYTE_W-1:0]   win [REG_BYTES];
    int unsigned         fill = 0;
    logic [RCOUNT_W-1:0] hits = '0;

    t_text_out   rewritten_q[$];
    logic [8:0]  feed_q[$];
    logic [8:0]  feed_head;
    bit          in_pending  = 1'b0;
    bit          idle_on     = 1'b1;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          stall_mode  = 1;
    int          stall_left  = 0;
    int          err_count   = 0;
    int          cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < REG_BYTES; i++) win[i] = '0;
    end

    // ------------------------------------------------------------------
    // rewriter
    // ------------------------------------------------------------------
    function automatic void emit_text(logic [BYTE_W-1:0] b, logic v);
        t_text_out e;
        e.text = b;
        e.vld  = v;
        e.fin  = 1'b0;
        e.cnt  = hits;
        rewritten_q.push_back(e);
    endfunction

    function automatic void rewrite_byte(logic [BYTE_W-1:0] b, logic eos);
        int unsigned n;
        int unsigned i;
        bit          hit;
        n = 0;
        if (!in_stream) begin
            act_find  = cfg_find;
            act_repl  = cfg_repl;
            act_flen  = (cfg_flen > MAX_FIND_DEF) ? MAX_FIND_DEF : cfg_flen;
            act_rlen  = (cfg_rlen > MAX_REPLACE_DEF) ? MAX_REPLACE_DEF : cfg_rlen;
            in_stream = 1'b1;
        end
        if (act_flen == 0) begin
            emit_text(b, 1'b1);
            n++;
        end else begin
            if (fill < REG_BYTES) begin
                win[fill] = b;
                fill++;
            end
            if (fill >= act_flen) begin
                hit = 1'b1;
                for (i = 0; i < act_flen; i++)
                    if (win[i] != act_find[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    if (hits != '1) hits++;
                    for (i = 0; i < act_rlen; i++) begin
                        emit_text(act_repl[8*i +: 8], 1'b1);
                        n++;
                    end
                    fill = 0;
                end else begin
                    emit_text(win[0], 1'b1);
                    n++;
                    for (i = 0; i < REG_BYTES - 1; i++) win[i] = win[i+1];
                    win[REG_BYTES-1] = '0;
                    fill--;
                end
            end
        end
        if (eos) begin
            for (i = 0; i < fill; i++) begin
                emit_text(win[i], 1'b1);
                n++;
            end
            if (n == 0) emit_text('0, 1'b0);
            rewritten_q[rewritten_q.size()-1].fin = 1'b1;
            for (i = 0; i < REG_BYTES; i++) win[i] = '0;
            fill      = 0;
            hits      = '0;
            in_stream = 1'b0;
        end
    endfunction

    task automatic report(input string msg);
        err_count++;
        if (err_count <= MAX_ERR_LOG)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_result();
        t_text_out want;
        if (rewritten_q.size() == 0) begin
            report($sformatf("unexpected item byte=%02h valid=%0b last=%0b count=%0d",
                             o_out_byte, o_byte_valid, o_last, o_replace_count));
        end else begin
            want = rewritten_q.pop_front();
            if (o_out_byte !== want.text)
                report($sformatf("out_byte %02h, want %02h", o_out_byte, want.text));
            if (o_byte_valid !== want.vld)
                report($sformatf("byte_valid %0b, want %0b", o_byte_valid, want.vld));
            if (o_last !== want.fin)
                report($sformatf("last %0b, want %0b", o_last, want.fin));
            if (o_replace_count !== want.cnt)
                report($sformatf("replace_count %0d, want %0d", o_replace_count, want.cnt));
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: register writes, accepted bytes, output items
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FIND_BYTES:     cfg_find = i_cfg_data;
                    REG_FIND_LENGTH:    cfg_flen = i_cfg_data[LEN_W-1:0];
                    REG_REPLACE_BYTES:  cfg_repl = i_cfg_data;
                    REG_REPLACE_LENGTH: cfg_rlen = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                rewrite_byte(i_in_byte, i_end_of_stream);
                in_pending = 1'b0;
            end
            if (o_out_valid && i_out_ready)
                check_result();
        end
    end

    // ------------------------------------------------------------------
    // sender: bursts with gaps between them
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !in_pending) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (feed_q.size() > 0) begin
                feed_head = feed_q.pop_front();
                i_in_byte       <= feed_head[7:0];
                i_end_of_stream <= feed_head[8];
                i_in_valid      <= 1'b1;
                in_pending = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if (idle_on) begin
                    burst_left = $urandom_range(0, 11);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: short or long stalls, or none, depending on stall_mode
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (stall_mode != 0 && $urandom_range(0, 99) < 30)
                stall_left = $urandom_range(1, (stall_mode == 2) ? 20 : 4);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("** stream_find_and_replace: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (feed_q.size() >= 4) @(posedge i_clk);
        feed_q.push_back({eos, b});
    endtask

    task automatic drain(input int settle);
        while (feed_q.size() != 0 || in_pending || rewritten_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pattern(input logic [CFG_W-1:0] find, input logic [LEN_W-1:0] flen,
                               input logic [CFG_W-1:0] repl, input logic [LEN_W-1:0] rlen);
        drain(SETTLE);
        write_reg(REG_FIND_BYTES, find);
        write_reg(REG_FIND_LENGTH, CFG_W'(flen));
        write_reg(REG_REPLACE_BYTES, repl);
        write_reg(REG_REPLACE_LENGTH, CFG_W'(rlen));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_passthrough();
        set_pattern(64'hA5A5_0000_FFFF_1234, 4'd0, 64'h0011_2233_4455_6677, 4'd5);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_replace_and_flush();
        // "ab" -> "XYZ", stream "abcaab" then a lone "a" left in the window
        set_pattern(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b1);
    endtask

    task automatic test_delete_to_end_marker();
        set_pattern(64'h41, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_oversized_lengths();
        logic [CFG_W-1:0] find;
        find = 64'hFF00_FF00_FF00_FF00;
        set_pattern(find, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd15);
        for (int i = 0; i < REG_BYTES; i++)
            send_byte(find[8*i +: 8], i == REG_BYTES - 1);
    endtask

    task automatic test_register_latch();
        // a write mid-stream only applies to the next stream
        set_pattern(64'h71, 4'd1, 64'h51, 4'd1);
        send_byte(8'h71, 1'b0);
        drain(SETTLE);
        write_reg(REG_FIND_BYTES, 64'h7A);
        send_byte(8'h71, 1'b0);
        send_byte(8'h7A, 1'b1);
    endtask

    task automatic test_count_run();
        idle_on    = 1'b0;
        stall_mode = 0;
        set_pattern(64'h2E, 4'd1, 64'h2A, 4'd1);
        for (int i = 0; i < 10; i++)
            send_byte(8'h2E, 1'b0);
        send_byte(8'h21, 1'b1);
        drain(0);
        idle_on    = 1'b1;
        stall_mode = 1;
    endtask

    task automatic test_random_streams();
        logic [7:0]       alpha [3];
        logic [7:0]       text_buf[$];
        logic [CFG_W-1:0] find;
        int               flen;
        int               rlen;
        int               p;
        int               k;
        int               len;
        int               pause_at;
        int               sent;
        int               r;
        bit               first;
        sent  = 0;
        first = 1'b1;
        while (sent < 90) begin
            for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(0, 255));
            for (int i = 0; i < REG_BYTES; i++) find[8*i +: 8] = alpha[$urandom_range(0, 2)];
            r    = $urandom_range(0, 11);
            flen = (r <= 8) ? r : $urandom_range(9, 15);
            r    = $urandom_range(0, 10);
            rlen = (r <= 8) ? r : $urandom_range(9, 15);
            set_pattern(find, LEN_W'(flen), {$urandom, $urandom}, LEN_W'(rlen));
            idle_on    = ($urandom_range(0, 3) != 0);
            stall_mode = $urandom_range(0, 2);
            p   = (flen > MAX_FIND_DEF) ? MAX_FIND_DEF : flen;
            len = $urandom_range(1, 16);
            text_buf.delete();
            while (text_buf.size() < len) begin
                r = $urandom_range(0, 9);
                if (p > 0 && r < 5) begin
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, p - 1) : p;
                    for (int j = 0; j < k; j++) text_buf.push_back(find[8*j +: 8]);
                end else if (r < 9) begin
                    text_buf.push_back(alpha[$urandom_range(0, 2)]);
                end else begin
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            pause_at = (first || $urandom_range(0, 3) == 0) ?
                       $urandom_range(0, text_buf.size() - 1) : -1;
            for (int i = 0; i < text_buf.size(); i++) begin
                if (i == pause_at) drain(0);
                send_byte(text_buf[i], i == text_buf.size() - 1);
            end
            sent += text_buf.size();
            first = 1'b0;
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_passthrough();
        test_replace_and_flush();
        test_delete_to_end_marker();
        test_oversized_lengths();
        test_register_latch();
        test_count_run();
        test_random_streams();

        drain(SETTLE);
        if (err_count == 0)
            $display("** stream_find_and_replace: PASSED **");
        else
            $display("** stream_find_and_replace: FAILED **");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cell.sv
hw/rtl/sfr_out_buf.sv
hw/rtl/stream_find_and_replace.sv
test/tb_stream_find_and_replace.sv
